// ===== rtl/core/sipq_pkg.sv =====
// Shared constants and types for the sorted-insert priority queue.
package sipq_pkg;

   // Queue geometry
   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;
   localparam int OCC_W = 5;

   // Operation codes carried by req_cmd
   localparam logic CMD_STORE    = 1'b0;
   localparam logic CMD_RETRIEVE = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic {
      CTL_IDLE,
      CTL_HOLD
   } ctl_state_type;

   // Controller to datapath command
   typedef struct packed {
      logic       load;
      logic       insert;
      logic       pop;
      status_type code;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic empty;
      logic full;
   } dp_stat_type;

endpackage

// ===== rtl/core/sipq_datapath.sv =====
// Datapath: row of compare-and-shift cells, entry count and result registers.
module sipq_datapath
   import sipq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   input  logic signed [VAL_W-1:0] value,
   output dp_stat_type             stat,
   output logic signed [VAL_W-1:0] out_value,
   output logic [1:0]              status,
   output logic [OCC_W-1:0]        occupancy
);

   logic signed [VAL_W-1:0] entries_ff [DEPTH];
   logic signed [VAL_W-1:0] entries_in [DEPTH];
   logic signed [VAL_W-1:0] ent_dn [DEPTH];
   logic signed [VAL_W-1:0] ent_up [DEPTH];
   logic [DEPTH-1:0]        gt;
   logic [DEPTH-1:0]        prev_gt;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic signed [VAL_W-1:0] out_value_ff;
   logic [1:0]              status_ff;
   logic [OCC_W-1:0]        occupancy_ff;

   // Status toward the controller
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(DEPTH));

   // Per-cell compare: a live entry strictly above the new value moves up
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] > value);
      end
      prev_gt = {gt[DEPTH-2:0], 1'b0};
   end

   // Neighbor taps for shifting up (insert) and down (pop)
   always_comb begin
      ent_dn[0]       = entries_ff[0];
      ent_up[DEPTH-1] = entries_ff[DEPTH-1];
      for (int i = 1; i < DEPTH; i++) begin
         ent_dn[i]   = entries_ff[i-1];
         ent_up[i-1] = entries_ff[i];
      end
   end

   // Next entry of each cell
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         if (cmd.insert) begin
            if (prev_gt[i]) begin
               entries_in[i] = ent_dn[i];
            end else if (gt[i] || (CNT_W'(i) == count_ff)) begin
               entries_in[i] = value;
            end
         end else if (cmd.pop) begin
            entries_in[i] = ent_up[i];
         end
      end
   end

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Cell storage and result registers, no reset needed
   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (cmd.load) begin
         out_value_ff <= cmd.pop ? entries_ff[0] : '0;
         status_ff    <= cmd.code;
         occupancy_ff <= OCC_W'(count_in);
      end
   end

   assign out_value = out_value_ff;
   assign status    = status_ff;
   assign occupancy = occupancy_ff;

endmodule

// ===== rtl/core/sipq_ctrl.sv =====
// Controller: handshake state machine that issues datapath commands.
module sipq_ctrl
   import sipq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b0;
      rsp_valid  = 1'b0;
      cmd.load   = 1'b0;
      cmd.insert = 1'b0;
      cmd.pop    = 1'b0;
      cmd.code   = ST_OK;
      case (state_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
         end
         CTL_HOLD: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            if (!rsp_stall) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
      accept = req_valid && !req_stall;
      // New beat: result slot is free or being emptied this cycle
      if (accept) begin
         state_in = CTL_HOLD;
         cmd.load = 1'b1;
         if (req_cmd == CMD_STORE) begin
            if (stat.full) begin
               cmd.code = ST_FULL;
            end else begin
               cmd.insert = 1'b1;
            end
         end else begin
            if (stat.empty) begin
               cmd.code = ST_EMPTY;
            end else begin
               cmd.pop = 1'b1;
            end
         end
      end
   end

endmodule

// ===== rtl/core/sorted_insert_priority_queue.sv =====
// A beat's result is presented in the cycle after the beat is accepted.
// Throughput: one beat per cycle while rsp_stall is low; the compare-and-shift
// cell row inserts or pops on acceptance, and a new beat is taken while the held
// result is taken. Reset (synchronous, active high) empties the queue and drops
// any held result; stored cell values are not cleared.
module sorted_insert_priority_queue
   import sipq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_cmd,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [VAL_W-1:0] rsp_out_value,
   output logic [1:0]              rsp_status,
   output logic [OCC_W-1:0]        rsp_occupancy
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sipq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sipq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .value     (req_value),
      .stat      (stat),
      .out_value (rsp_out_value),
      .status    (rsp_status),
      .occupancy (rsp_occupancy)
   );

endmodule

// ===== rtl/core/sipq_checker.sv =====
// Port-level checker for the priority queue and its bind to the top level.
module sipq_checker
   import sipq_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [VAL_W-1:0] rsp_out_value,
   input logic [1:0]              rsp_status,
   input logic [OCC_W-1:0]        rsp_occupancy
);

   // Every accepted beat yields a result on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("no result after accepted beat");

   // A stalled result holds
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_status) && $stable(rsp_occupancy)))
      else $error("stalled result changed");

   // Empty status means nothing returned and nothing stored
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_out_value == '0
         && rsp_occupancy == '0))
      else $error("bad empty result");

   // Full status reports a full queue and returns zero
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_out_value == '0
         && rsp_occupancy == OCC_W'(DEPTH)))
      else $error("bad full result");

   // No result right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sorted_insert_priority_queue sipq_checker u_sipq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_value (rsp_out_value),
   .rsp_status    (rsp_status),
   .rsp_occupancy (rsp_occupancy)
);
